[design/rlebf_pkg.sv]
package rlebf_pkg;

    localparam int WORD_BITS = 64;
    localparam int PIX_W     = 17;
    localparam int END_W     = 18;
    localparam int AREA_W    = 24;

    localparam logic [AREA_W-1:0] AREA_MAX      = 24'hFF_FFFF;
    localparam logic [PIX_W-1:0]  PIXELS_RESET  = 17'd65536;
    localparam int                APB_ADDR_W    = 3;
    localparam logic              REG_IMAGE_PIXELS = 1'b0;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FILL,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  run_start;
        logic [16:0]  run_length;
        logic [9:0]   read_word;
    } req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 status;
        logic [AREA_W-1:0]    area_total;
    } rsp_t;

endpackage

[design/rle_run_bitmask_fill_core.sv]
// A read, a rejected or empty run and an unused kind go from IDLE to DONE, where the result is registered;
// an accepted run goes through FILL, one memory read-modify-write per word spanned,
// pipelined through the single read port and single write port of the bitmap memory,
// then DRAIN and DONE. One request at a time; a clear request sweeps every word to zero.
// Reset: control state clears at once, then a sweep over every word zeroes the bitmap
// while in_stall stays high; configuration writes are taken throughout.
module rle_run_bitmask_fill_core #(
    parameter int BITMAP_WORDS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rlebf_pkg::req_t                      in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rlebf_pkg::rsp_t                      out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rlebf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rlebf_pkg::*;

    localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CUR_EXT_W = (ADDR_W > 12) ? ADDR_W : 12;
    localparam int IDX_EXT_W = (ADDR_W > 10) ? ADDR_W : 10;
    localparam logic [22:0] CAP_PIXELS = 23'(BITMAP_WORDS * WORD_BITS);
    localparam logic [16:0] WORDS_17 = 17'(BITMAP_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_WORDS - 1);

    logic [WORD_BITS-1:0] mask_mem [BITMAP_WORDS];

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    sweep_cnt_reg;
    logic                 sweep_item_reg;
    kind_t                kind_reg;
    logic                 status_reg;
    logic                 in_range_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [PIX_W-1:0]     pixels_reg;
    logic [END_W-1:0]     cur_reg;
    logic [END_W-1:0]     end_reg;
    logic                 wr_pend_reg;
    logic [ADDR_W-1:0]    wr_addr_reg;
    logic [WORD_BITS-1:0] wr_mask_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 out_valid_reg;
    rsp_t                 out_data_reg;

    logic                 accept;
    logic                 cfg_write;
    logic [END_W-1:0]     run_end;
    logic                 run_reject;
    logic                 idx_in_range;
    logic [AREA_W:0]      area_sum;
    logic [AREA_W-1:0]    area_new;
    logic                 out_load;

    logic [END_W-1:0]     next_base;
    logic                 last_word;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] word_mask;
    logic [CUR_EXT_W-1:0] cur_word_ext;
    logic [IDX_EXT_W-1:0] idx_ext;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // request decode
    assign accept       = in_valid && !in_stall;
    assign run_end      = END_W'(in_data.run_start) + END_W'(in_data.run_length);
    assign run_reject   = (run_end > END_W'(pixels_reg)) || (23'(run_end) > CAP_PIXELS);
    assign idx_in_range = 17'(in_data.read_word) < WORDS_17;
    assign area_sum     = (AREA_W+1)'(area_reg) + (AREA_W+1)'(in_data.run_length);
    assign area_new     = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
    assign idx_ext      = IDX_EXT_W'(in_data.read_word);

    // per-word mask of the run
    assign next_base    = {cur_reg[END_W-1:6], 6'd0} + END_W'(WORD_BITS);
    assign last_word    = end_reg <= next_base;
    assign lo_mask      = {WORD_BITS{1'b1}} << cur_reg[5:0];
    assign hi_mask      = (last_word && (end_reg[5:0] != 6'd0))
                          ? ~({WORD_BITS{1'b1}} << end_reg[5:0]) : {WORD_BITS{1'b1}};
    assign word_mask    = lo_mask & hi_mask;
    assign cur_word_ext = CUR_EXT_W'(cur_reg[END_W-1:6]);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_PIXELS);
    assign prdata    = (paddr[2] == REG_IMAGE_PIXELS) ? 32'(pixels_reg) : 32'd0;

    assign out_load  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == LAST_ADDR)
                begin
                    state_next = sweep_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.kind) inside
                        KIND_CLEAR: state_next = ST_SWEEP;
                        KIND_RUN:
                        begin
                            if (!run_reject && (in_data.run_length != 17'd0))
                            begin
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        KIND_READ, KIND_NOP: state_next = ST_DONE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL:
            begin
                if (last_word)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        rd_addr  = cur_word_ext[ADDR_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = wr_addr_reg;
        wr_data  = rdata_reg | wr_mask_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_cnt_reg;
                wr_data = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_en    = accept && (in_data.kind == KIND_READ) && idx_in_range;
                rd_addr  = idx_ext[ADDR_W-1:0];
            end
            ST_FILL:
            begin
                rd_en = 1'b1;
                wr_en = wr_pend_reg;
            end
            ST_DRAIN:
            begin
                wr_en = wr_pend_reg;
            end
            ST_DONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mask_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mask_mem[rd_addr];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg      <= END_W'(in_data.run_start);
            end_reg      <= run_end;
            in_range_reg <= idx_in_range;
        end
        else if (state_reg == ST_FILL)
        begin
            cur_reg <= {next_base[END_W-1:6], 6'd0};
        end
        if (state_reg == ST_FILL)
        begin
            wr_addr_reg <= cur_word_ext[ADDR_W-1:0];
            wr_mask_reg <= word_mask;
        end
        if ((state_reg == ST_DONE) && out_load)
        begin
            out_data_reg.read_data  <= ((kind_reg == KIND_READ) && in_range_reg)
                                       ? rdata_reg : '0;
            out_data_reg.status     <= status_reg;
            out_data_reg.area_total <= area_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_cnt_reg  <= '0;
            sweep_item_reg <= 1'b0;
            kind_reg       <= KIND_NOP;
            status_reg     <= 1'b0;
            area_reg       <= '0;
            pixels_reg     <= PIXELS_RESET;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pend_reg <= (state_reg == ST_FILL);
            if (cfg_write)
            begin
                pixels_reg <= pwdata[PIX_W-1:0];
            end
            if (state_reg == ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                kind_reg       <= in_data.kind;
                status_reg     <= (in_data.kind == KIND_RUN) && run_reject;
                sweep_cnt_reg  <= '0;
                sweep_item_reg <= (in_data.kind == KIND_CLEAR);
                if (in_data.kind == KIND_CLEAR)
                begin
                    area_reg <= '0;
                end
                else if ((in_data.kind == KIND_RUN) && !run_reject)
                begin
                    area_reg <= area_new;
                end
            end
            if ((state_reg == ST_DONE) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // checks
    a_write_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> ((state_reg == ST_FILL) || (state_reg == ST_DRAIN)))
        else $error("pending write outside a run");

    a_no_same_word_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FILL) && wr_pend_reg) |-> (rd_addr != wr_addr_reg))
        else $error("read and write of the same word in one cycle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside done state");

    a_status_only_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && status_reg) |-> (kind_reg == KIND_RUN))
        else $error("status set on a request that is not a run");

    a_area_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.kind != KIND_CLEAR)) |=> (area_reg >= $past(area_reg)))
        else $error("area total dropped without a clear");

endmodule

[sim/tb_rle_run_bitmask_fill_core.sv]
`timescale 1ns / 100ps

module tb_rle_run_bitmask_fill_core;

    import rlebf_pkg::*;

    localparam int BITMAP_WORDS   = 1024;
    localparam int CAPACITY       = BITMAP_WORDS * WORD_BITS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 64;
    localparam logic [APB_ADDR_W-1:0] PIXELS_ADDR = APB_ADDR_W'(4 * REG_IMAGE_PIXELS);

    typedef struct packed {
        req_t req;
        logic pinned;
        rsp_t rsp;
    } step_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    req_t                  in_data    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    rsp_t                  out_data;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic                  in_pinned  = 1'b0;
    rsp_t                  pinned_rsp = '0;

    logic [WORD_BITS-1:0]  bitmap_shadow [BITMAP_WORDS];
    logic [AREA_W-1:0]     area_shadow  = '0;
    logic [PIX_W-1:0]      pixel_limit  = PIXELS_RESET;
    rsp_t                  owed_responses [$];

    int                    fail_count         = 0;
    int                    quiet_cycles       = 0;
    int                    sender_idle_pct    = 0;
    int                    receiver_stall_pct = 0;
    int                    hold_asks          = 0;

    step_row_t directed_rows [$] = '{
        '{'{KIND_READ,  16'd0,     17'd0,      10'd0},    1'b1, '{64'd0, 1'b0, 24'd0}},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd1023}, 1'b1, '{64'd0, 1'b0, 24'd0}},
        '{'{KIND_RUN,   16'd0,     17'd0,      10'd0},    1'b1, '{64'd0, 1'b0, 24'd0}},
        '{'{KIND_RUN,   16'd0,     17'd1,      10'd0},    1'b1, '{64'd0, 1'b0, 24'd1}},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd0},    1'b1, '{64'd1, 1'b0, 24'd1}},
        '{'{KIND_RUN,   16'd63,    17'd2,      10'd0},    1'b0, '0},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd0},    1'b0, '0},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd1},    1'b0, '0},
        '{'{KIND_RUN,   16'hFFFF,  17'd1,      10'd0},    1'b1, '{64'd0, 1'b0, 24'd4}},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd1023}, 1'b1,
            '{64'h8000_0000_0000_0000, 1'b0, 24'd4}},
        '{'{KIND_RUN,   16'hFFFF,  17'd2,      10'd0},    1'b1, '{64'd0, 1'b1, 24'd4}},
        '{'{KIND_RUN,   16'd0,     17'h1FFFF,  10'd0},    1'b1, '{64'd0, 1'b1, 24'd4}},
        '{'{KIND_RUN,   16'hFFFF,  17'h1FFFF,  10'd0},    1'b1, '{64'd0, 1'b1, 24'd4}},
        '{'{KIND_RUN,   16'd0,     17'd65536,  10'd0},    1'b0, '0},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd512},  1'b1, '{'1, 1'b0, 24'd65540}},
        '{'{KIND_NOP,   16'hFFFF,  17'h1FFFF,  10'h3FF},  1'b1, '{64'd0, 1'b0, 24'd65540}},
        '{'{KIND_CLEAR, 16'd0,     17'd0,      10'd0},    1'b1, '{64'd0, 1'b0, 24'd0}},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd512},  1'b1, '{64'd0, 1'b0, 24'd0}},
        '{'{KIND_RUN,   16'd100,   17'd300,    10'd0},    1'b0, '0},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd1},    1'b0, '0},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd2},    1'b0, '0},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd6},    1'b0, '0},
        '{'{KIND_RUN,   16'hFFFF,  17'd0,      10'd0},    1'b0, '0},
        '{'{KIND_CLEAR, 16'hFFFF,  17'h1FFFF,  10'h3FF},  1'b1, '{64'd0, 1'b0, 24'd0}},
        '{'{KIND_READ,  16'd0,     17'd0,      10'd1023}, 1'b1, '{64'd0, 1'b0, 24'd0}}
    };

    rle_run_bitmask_fill_core #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int least(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic rsp_t apply_to_shadow(input req_t r);
        rsp_t                 rsp;
        int                   lim;
        int                   first;
        int                   stop;
        int                   base;
        int                   lo;
        int                   hi;
        int                   sum;
        logic [WORD_BITS-1:0] ones;
        rsp = '0;
        case (r.kind)
            KIND_CLEAR:
            begin
                foreach (bitmap_shadow[w])
                    bitmap_shadow[w] = '0;
                area_shadow = '0;
            end
            KIND_RUN:
            begin
                lim   = least(int'(pixel_limit), CAPACITY);
                first = int'(r.run_start);
                stop  = first + int'(r.run_length);
                if (stop > lim)
                begin
                    rsp.status = 1'b1;
                end
                else
                begin
                    for (int w = first / WORD_BITS; w * WORD_BITS < stop; w++)
                    begin
                        base = w * WORD_BITS;
                        lo   = (first > base) ? first - base : 0;
                        hi   = least(stop - base, WORD_BITS);
                        if (hi - lo >= WORD_BITS)
                            ones = '1;
                        else
                            ones = ((64'd1 << (hi - lo)) - 64'd1) << lo;
                        bitmap_shadow[w] = bitmap_shadow[w] | ones;
                    end
                    sum = int'(area_shadow) + int'(r.run_length);
                    area_shadow = (sum > int'(AREA_MAX)) ? AREA_MAX : AREA_W'(sum);
                end
            end
            KIND_READ:
            begin
                if (int'(r.read_word) < BITMAP_WORDS)
                    rsp.read_data = bitmap_shadow[r.read_word];
            end
            default:
            begin
            end
        endcase
        rsp.area_total = area_shadow;
        return rsp;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        logic [63:0] noise;
        int          lim;
        int          len;
        int          pick;
        noise = {$urandom, $urandom};
        r     = req_t'(noise[$bits(req_t)-1:0]);
        lim   = least(int'(pixel_limit), CAPACITY);
        pick  = $urandom_range(99);
        if (pick < 2)
        begin
            r.kind = KIND_CLEAR;
        end
        else if (pick < 5)
        begin
            r.kind = KIND_NOP;
        end
        else if (pick < 10)
        begin
        end
        else if (pick < 38)
        begin
            r.kind = KIND_READ;
            if ($urandom_range(3) != 0 && lim > 0)
                r.read_word = 10'($urandom_range((lim - 1) / WORD_BITS));
        end
        else
        begin
            r.kind = KIND_RUN;
            pick   = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(least(200, lim));
            else if (pick < 95)
                len = $urandom_range(least(2000, lim));
            else
                len = $urandom_range(lim);
            r.run_length = 17'(len);
            r.run_start  = 16'(least($urandom_range(lim - len), 65535));
            if ($urandom_range(9) == 0)
                r.run_start = 16'(least(lim - len + $urandom_range(2), 65535));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : check_responses
        rsp_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_responses.size() == 0)
                begin
                    $error("response with no request outstanding: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (out_data.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, out_data.read_data);
                        fail_count++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.area_total !== want.area_total)
                    begin
                        $error("area_total: expected %0d, got %0d",
                               want.area_total, out_data.area_total);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_to_shadow(in_data);
                if (in_pinned)
                    want = pinned_rsp;
                owed_responses = {owed_responses, want};
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_rle_run_bitmask_fill_core: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin : drive_stall
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic send_request(input req_t r, input logic pinned, input rsp_t typed);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= r;
        in_pinned  <= pinned;
        pinned_rsp <= typed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_responses();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int pixels, input int send_pct, input int stall_pct,
                             input int count, input logic pressure);
        drain_responses();
        write_register(PIXELS_ADDR, 32'(pixels));
        pixel_limit        = PIX_W'(pixels);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == 40)
                hold_asks <= hold_asks + 1;
            send_request(random_request(), 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        req_t r;
        int   len;
        foreach (bitmap_shadow[w])
            bitmap_shadow[w] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rsp);

        run_phase(4096, 0, 0, 250, 1'b1);
        run_phase(1, 47, 0, 150, 1'b0);
        run_phase(0, 0, 47, 150, 1'b0);
        run_phase(131071, 19, 19, 250, 1'b0);

        // drive the area total into saturation with near-full runs
        run_phase(65536, 0, 0, 0, 1'b0);
        for (int i = 0; i < 270; i++)
        begin
            len          = $urandom_range(64000, 65536);
            r            = '0;
            r.kind       = KIND_RUN;
            r.run_length = 17'(len);
            r.run_start  = 16'(least($urandom_range(65536 - len), 65535));
            r.read_word  = 10'($urandom);
            send_request(r, 1'b0, '0);
        end

        run_phase(65535, 47, 0, 220, 1'b0);
        run_phase($urandom_range(1, 65536), 19, 19, 250, 1'b0);

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (owed_responses.size() != 0)
            $error("%0d responses never arrived", owed_responses.size());
        if (fail_count == 0 && owed_responses.size() == 0)
            $display("tb_rle_run_bitmask_fill_core: clean");
        else
            $display("tb_rle_run_bitmask_fill_core: errors");
        $finish;
    end

endmodule
